[rtl/cosq_pkg.sv]
// ----------------------------------------------------------------------------
// cosq_pkg
// Shared types and constants for the co-clustering similarity query unit.
// ----------------------------------------------------------------------------
package cosq_pkg;

	localparam int POINT_W   = 6;
	localparam int ITER_W    = 6;
	localparam int LABEL_W   = 4;
	localparam int COUNT_W   = 7;
	localparam int FRAC_W    = 16;
	localparam int SIM_W     = FRAC_W + 1;
	localparam int REG_W     = 7;
	localparam int ADDR_W    = POINT_W + ITER_W;
	localparam int DEPTH     = 1 << ADDR_W;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int DIV_STEPS = FRAC_W;
	localparam int STEP_W    = 5;

	localparam logic [REG_W-1:0]   MAX_ITER      = REG_W'(64);
	localparam logic [REG_W-1:0]   ITER_RESET    = REG_W'(64);
	localparam logic [PADDR_W-1:0] REG_ITER_ADDR = '0;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [POINT_W-1:0] point_a;
		logic [POINT_W-1:0] point_b;
		logic [ITER_W-1:0]  iteration;
		logic [LABEL_W-1:0] label;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_RESULT
	} state_t;

endpackage

[rtl/cosq_ram.sv]
// ----------------------------------------------------------------------------
// cosq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cosq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/cosq_front.sv]
// ----------------------------------------------------------------------------
// cosq_front
// Accepts input requests, decodes the opcode and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module cosq_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [cosq_pkg::POINT_W-1:0]        point_a,
	input  logic [cosq_pkg::POINT_W-1:0]        point_b,
	input  logic [cosq_pkg::ITER_W-1:0]         iteration,
	input  logic [cosq_pkg::LABEL_W-1:0]        label,
	output logic                                q_valid,
	output cosq_pkg::req_t                      q_req,
	input  logic                                q_pop
);

	cosq_pkg::req_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cosq_pkg::req_t req_in;

	always_comb begin
		req_in.op        = opcode ? cosq_pkg::OP_QUERY : cosq_pkg::OP_WRITE;
		req_in.point_a   = point_a;
		req_in.point_b   = point_b;
		req_in.iteration = iteration;
		req_in.label     = label;
	end

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != 2'd0);
	assign q_req    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop && q_valid})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/cosq_div.sv]
// ----------------------------------------------------------------------------
// cosq_div
// Restoring divider: (count << 16) / n, one quotient bit per cycle.
// Relies on count <= n, so the integer part is a single bit.
// ----------------------------------------------------------------------------
module cosq_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cosq_pkg::COUNT_W-1:0]  count,
	input  logic [cosq_pkg::REG_W-1:0]    divisor,
	output logic                          busy,
	output logic [cosq_pkg::SIM_W-1:0]    quotient
);

	logic [cosq_pkg::REG_W-1:0]  rem_q;
	logic [cosq_pkg::REG_W-1:0]  div_q;
	logic [cosq_pkg::SIM_W-1:0]  quot_q;
	logic [cosq_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic [cosq_pkg::REG_W:0]    trial;
	logic                        fits;
	logic                        int_bit;

	assign int_bit  = (count >= divisor);
	assign trial    = {rem_q, 1'b0};
	assign fits     = (trial >= {1'b0, div_q});
	assign busy     = busy_q;
	assign quotient = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			rem_q  <= int_bit ? (count - divisor) : count;
			quot_q <= {{(cosq_pkg::SIM_W-1){1'b0}}, int_bit};
		end else if (busy_q) begin
			rem_q  <= fits ? cosq_pkg::REG_W'(trial - {1'b0, div_q})
			               : cosq_pkg::REG_W'(trial);
			quot_q <= {quot_q[cosq_pkg::SIM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == cosq_pkg::STEP_W'(cosq_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/cosq_back.sv]
// ----------------------------------------------------------------------------
// cosq_back
// Executes queued requests: label writes go straight to both label RAMs,
// queries scan two rows, count equal labels and divide by the row length.
// ----------------------------------------------------------------------------
module cosq_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  cosq_pkg::req_t                q_req,
	output logic                          q_pop,
	input  logic [cosq_pkg::REG_W-1:0]    n_eff,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cosq_pkg::COUNT_W-1:0]  match_count,
	output logic [cosq_pkg::SIM_W-1:0]    similarity
);

	cosq_pkg::state_t state_q, state_d;

	logic [cosq_pkg::POINT_W-1:0] pa_q, pb_q;
	logic [cosq_pkg::ITER_W-1:0]  idx_q, last_idx_q;
	logic [cosq_pkg::REG_W-1:0]   div_n_q;
	logic [cosq_pkg::COUNT_W-1:0] count_q;
	logic                         cmp_valid_s1;
	logic                         out_valid_q;
	logic [cosq_pkg::COUNT_W-1:0] out_count_q;
	logic [cosq_pkg::SIM_W-1:0]   out_sim_q;

	logic                         we;
	logic [cosq_pkg::ADDR_W-1:0]  waddr;
	logic [cosq_pkg::LABEL_W-1:0] rdata_a, rdata_b;
	logic                         div_start, div_busy;
	logic [cosq_pkg::SIM_W-1:0]   div_quot;
	logic                         out_load;
	logic                         take_query;

	assign we         = (state_q == cosq_pkg::ST_IDLE) && q_valid &&
	                    (q_req.op == cosq_pkg::OP_WRITE);
	assign waddr      = {q_req.point_a, q_req.iteration};
	assign take_query = (state_q == cosq_pkg::ST_IDLE) && q_valid &&
	                    (q_req.op == cosq_pkg::OP_QUERY);
	assign div_start  = (state_q == cosq_pkg::ST_DIV_START);
	assign out_load   = (state_q == cosq_pkg::ST_RESULT) && (!out_valid_q || !out_stall);

	// Two copies of the label table so both rows read in the same cycle.
	cosq_ram #(.WIDTH(cosq_pkg::LABEL_W), .DEPTH(cosq_pkg::DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (q_req.label),
		.raddr ({pa_q, idx_q}),
		.rdata (rdata_a)
	);

	cosq_ram #(.WIDTH(cosq_pkg::LABEL_W), .DEPTH(cosq_pkg::DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (q_req.label),
		.raddr ({pb_q, idx_q}),
		.rdata (rdata_b)
	);

	cosq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.count    (count_q),
		.divisor  (div_n_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			cosq_pkg::ST_IDLE: begin
				q_pop = q_valid;
				if (take_query) begin
					state_d = cosq_pkg::ST_READ;
				end
			end
			cosq_pkg::ST_READ: begin
				if (idx_q == last_idx_q) begin
					state_d = cosq_pkg::ST_DRAIN;
				end
			end
			cosq_pkg::ST_DRAIN:     state_d = cosq_pkg::ST_DIV_START;
			cosq_pkg::ST_DIV_START: state_d = cosq_pkg::ST_DIV_RUN;
			cosq_pkg::ST_DIV_RUN: begin
				if (!div_busy) begin
					state_d = cosq_pkg::ST_RESULT;
				end
			end
			cosq_pkg::ST_RESULT: begin
				if (out_load) begin
					state_d = cosq_pkg::ST_IDLE;
				end
			end
			default: state_d = cosq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cosq_pkg::ST_IDLE;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cmp_valid_s1 <= (state_q == cosq_pkg::ST_READ);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read data comes the cycle after its address; it is compared then.
	always_ff @(posedge clk) begin
		if (take_query) begin
			pa_q       <= q_req.point_a;
			pb_q       <= q_req.point_b;
			idx_q      <= '0;
			last_idx_q <= cosq_pkg::ITER_W'(n_eff - 1'b1);
			div_n_q    <= n_eff;
			count_q    <= '0;
		end else begin
			if (state_q == cosq_pkg::ST_READ) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmp_valid_s1 && (rdata_a == rdata_b)) begin
				count_q <= count_q + 1'b1;
			end
		end
		if (out_load) begin
			out_count_q <= count_q;
			out_sim_q   <= div_quot;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = out_count_q;
	assign similarity  = out_sim_q;

endmodule

[rtl/coclustering_similarity_query_unit.sv]
// ----------------------------------------------------------------------------
// coclustering_similarity_query_unit
// Label table with pairwise co-clustering similarity queries.
//
// Input channel (in_valid/in_stall): a request with opcode 0 stores one label
// at (point_a, iteration) and gives no result; opcode 1 queries points
// point_a and point_b. Requests enter a two-entry queue, so the input stalls
// only when that queue is full. Requests are carried out in order.
// Output channel (out_valid/out_stall): one result per query, match_count and
// similarity = match_count / n in Q1.16, rounded down, n being the clamped
// iteration register (0 reads as 1, above 64 as 64).
// Sequence: a write goes from the queue straight into both label RAMs. A
// query scans both label rows at one RAM read per row per cycle (ST_READ),
// passes ST_DRAIN and ST_DIV_START, runs the bit-serial divider
// (ST_DIV_RUN) and waits in ST_RESULT until the output register takes the
// result. One query runs at a time; writes go at one per cycle while no query runs.
// A held result in the output register does not block acceptance; only a
// second finished query waits for the receiver.
// Reset clears the queue, sequencer and output valid and sets the register to
// 64; the label table is not cleared and must be written before it is read.
// Configuration register at byte address 0: iterations_in_use (7 bits).
// ----------------------------------------------------------------------------
module coclustering_similarity_query_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cosq_pkg::PADDR_W-1:0]        paddr,
	input  logic [cosq_pkg::PDATA_W-1:0]        pwdata,
	output logic [cosq_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [cosq_pkg::POINT_W-1:0]        point_a,
	input  logic [cosq_pkg::POINT_W-1:0]        point_b,
	input  logic [cosq_pkg::ITER_W-1:0]         iteration,
	input  logic [cosq_pkg::LABEL_W-1:0]        label,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cosq_pkg::COUNT_W-1:0]        match_count,
	output logic [cosq_pkg::SIM_W-1:0]          similarity
);

	logic [cosq_pkg::REG_W-1:0] iter_reg_q;
	logic [cosq_pkg::REG_W-1:0] n_eff;
	logic                       q_valid, q_pop;
	cosq_pkg::req_t             q_req;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_reg_q <= cosq_pkg::ITER_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (paddr == cosq_pkg::REG_ITER_ADDR)) begin
			iter_reg_q <= pwdata[cosq_pkg::REG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == cosq_pkg::REG_ITER_ADDR) begin
			prdata = {{(cosq_pkg::PDATA_W-cosq_pkg::REG_W){1'b0}}, iter_reg_q};
		end
	end

	always_comb begin
		if (iter_reg_q == '0) begin
			n_eff = cosq_pkg::REG_W'(1);
		end else if (iter_reg_q > cosq_pkg::MAX_ITER) begin
			n_eff = cosq_pkg::MAX_ITER;
		end else begin
			n_eff = iter_reg_q;
		end
	end

	cosq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.point_a   (point_a),
		.point_b   (point_b),
		.iteration (iteration),
		.label     (label),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop)
	);

	cosq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_pop       (q_pop),
		.n_eff       (n_eff),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_count (match_count),
		.similarity  (similarity)
	);

endmodule

[test/cosq_checker.sv]
// ----------------------------------------------------------------------------
// cosq_checker
// Watches the configuration port and both the input and output channels of the
// co-clustering similarity query unit, keeps its own label table and
// iteration register, predicts every query result and compares it field by
// field with what the unit returns. Failures are counted and handed out.
// ----------------------------------------------------------------------------
module cosq_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cosq_pkg::PADDR_W-1:0] paddr,
	input  logic [cosq_pkg::PDATA_W-1:0] pwdata,
	input  logic [cosq_pkg::PDATA_W-1:0] prdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        opcode,
	input  logic [cosq_pkg::POINT_W-1:0] point_a,
	input  logic [cosq_pkg::POINT_W-1:0] point_b,
	input  logic [cosq_pkg::ITER_W-1:0]  iteration,
	input  logic [cosq_pkg::LABEL_W-1:0] label,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [cosq_pkg::COUNT_W-1:0] match_count,
	input  logic [cosq_pkg::SIM_W-1:0]   similarity,
	output int                          fail_count,
	output int                          pending,
	output int                          query_total,
	output int                          write_total
);
	timeunit 1ns;
	timeprecision 1ps;
	import cosq_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SIM_W-1:0]   sim;
	} sim_result_t;

	sim_result_t        similarity_due [$];
	logic [LABEL_W-1:0] label_mirror [DEPTH];
	logic [REG_W-1:0]   iter_reg;
	int                 errors;

	// rows compared over the clamped iteration count; fraction rounded down
	function automatic sim_result_t predict_similarity(logic [POINT_W-1:0] pa,
			logic [POINT_W-1:0] pb);
		int unsigned      n;
		int unsigned      hits;
		logic [ITER_W-1:0] col;
		sim_result_t      r;
		if (iter_reg == '0)
			n = 1;
		else if (iter_reg > MAX_ITER)
			n = int'(MAX_ITER);
		else
			n = int'(iter_reg);
		hits = 0;
		for (int i = 0; i < n; i++) begin
			col = ITER_W'(i);
			if (label_mirror[{pa, col}] == label_mirror[{pb, col}])
				hits++;
		end
		r.count = COUNT_W'(hits);
		r.sim   = SIM_W'((hits << FRAC_W) / n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sim_result_t due;
		if (!arst_n) begin
			iter_reg = ITER_RESET;
			similarity_due.delete();
			errors = 0;
			query_total <= 0;
			write_total <= 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pready && paddr == REG_ITER_ADDR) begin
				if (pwrite) begin
					iter_reg = pwdata[REG_W-1:0];
				end else if (prdata !== PDATA_W'(iter_reg)) begin
					$error("prdata: expected %0d, actual %0d", iter_reg, prdata);
					errors++;
				end
			end

			if (in_valid && !in_stall) begin
				if (op_t'(opcode) == OP_WRITE) begin
					label_mirror[{point_a, iteration}] = label;
					write_total <= write_total + 1;
				end else begin
					similarity_due.push_back(predict_similarity(point_a, point_b));
					query_total <= query_total + 1;
				end
			end

			if (out_valid && !out_stall) begin
				if (similarity_due.size() == 0) begin
					$error("result with no query waiting: match_count %0d similarity %0d",
						match_count, similarity);
					errors++;
				end else begin
					due = similarity_due.pop_front();
					if (match_count !== due.count) begin
						$error("match_count: expected %0d, actual %0d", due.count, match_count);
						errors++;
					end
					if (similarity !== due.sim) begin
						$error("similarity: expected %0d, actual %0d", due.sim, similarity);
						errors++;
					end
				end
			end

			fail_count <= errors;
			pending <= similarity_due.size();
		end
	end

endmodule

[test/coclustering_similarity_query_unit_tb.sv]
// ----------------------------------------------------------------------------
// coclustering_similarity_query_unit_tb
// Drives label writes and pairwise queries into the unit across a range of
// iteration register settings and idling mixes, with one long output
// hold-off; a checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module coclustering_similarity_query_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cosq_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 1500;
	localparam int POOL_SIZE     = 8;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 150;
	localparam int PRESSURE_ITEMS = 60;
	localparam int NUM_POINTS    = 1 << POINT_W;
	localparam int NUM_ITERS     = 1 << ITER_W;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = 1'b0;
	logic [POINT_W-1:0] point_a = '0;
	logic [POINT_W-1:0] point_b = '0;
	logic [ITER_W-1:0]  iteration = '0;
	logic [LABEL_W-1:0] label = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COUNT_W-1:0] match_count;
	logic [SIM_W-1:0]   similarity;

	int fail_count;
	int pending;
	int query_total;
	int write_total;

	// which table entries have been written since reset; queries only read these
	bit               written [NUM_POINTS][NUM_ITERS];
	int               pool [POOL_SIZE];
	logic [REG_W-1:0] cur_reg = ITER_RESET;
	int               send_idle_pct = 12;
	int               recv_idle_pct = 73;
	bit               pressure_on = 1'b0;
	int               hold_count = 0;
	int               settings_count = 0;
	int               cycle_count = 0;

	coclustering_similarity_query_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.point_a(point_a), .point_b(point_b), .iteration(iteration), .label(label),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_count(match_count), .similarity(similarity)
	);

	cosq_checker sim_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.point_a(point_a), .point_b(point_b), .iteration(iteration), .label(label),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_count(match_count), .similarity(similarity),
		.fail_count(fail_count), .pending(pending),
		.query_total(query_total), .write_total(write_total)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: one long hold-off when pressure is asked for, random stalls otherwise
	always @(posedge clk) begin
		if (pressure_on && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic int eff_iters(logic [REG_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_ITER)
			return int'(MAX_ITER);
		return int'(v);
	endfunction

	function automatic int first_gap(int p, int n);
		for (int i = 0; i < n; i++)
			if (!written[p][i])
				return i;
		return -1;
	endfunction

	function automatic int pick_label();
		// narrow labels on most writes so that matches are frequent
		if ($urandom_range(99) < 80)
			return $urandom_range(3);
		return $urandom_range(15);
	endfunction

	task automatic send_item(op_t op, int a, int b, int it, int lab);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		point_a   <= POINT_W'(a);
		point_b   <= POINT_W'(b);
		iteration <= ITER_W'(it);
		label     <= LABEL_W'(lab);
		if (op == OP_WRITE)
			written[a][it] = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// a trailing write may still be in the back end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write, then read back; upper data bits are noise the register must drop
	task automatic write_reg(logic [REG_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ITER_ADDR;
		pwdata  <= {(PDATA_W-REG_W)'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		cur_reg = v;
		settings_count++;
	endtask

	task automatic random_item();
		int cand [$];
		int r, n, a, b, it;
		n = eff_iters(cur_reg);
		foreach (pool[k])
			if (first_gap(pool[k], n) < 0)
				cand.push_back(pool[k]);
		r = $urandom_range(99);
		if (cand.size() < 2) begin
			// too few complete rows: fill what a query would read
			a = pool[0];
			it = 0;
			foreach (pool[k]) begin
				if (first_gap(pool[k], n) >= 0) begin
					a = pool[k];
					it = first_gap(pool[k], n);
					break;
				end
			end
			send_item(OP_WRITE, a, $urandom_range(63), it, pick_label());
		end else if (r < 45) begin
			a = cand[$urandom_range(cand.size() - 1)];
			b = ($urandom_range(99) < 15) ? a : cand[$urandom_range(cand.size() - 1)];
			send_item(OP_QUERY, a, b, $urandom_range(63), $urandom_range(15));
		end else if (r < 82) begin
			a = pool[$urandom_range(POOL_SIZE - 1)];
			it = first_gap(a, NUM_ITERS);
			if (it < 0 || $urandom_range(99) < 30)
				it = $urandom_range(63);
			send_item(OP_WRITE, a, $urandom_range(63), it, pick_label());
		end else begin
			send_item(OP_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(63),
				$urandom_range(15));
		end
	endtask

	initial begin
		logic [REG_W-1:0] settings [PHASES];
		int p;
		bit dup;

		pool[0] = 0;
		pool[1] = NUM_POINTS - 1;
		pool[2] = 21;
		pool[3] = 42;
		for (int k = 4; k < POOL_SIZE; k++) begin
			do begin
				p = $urandom_range(NUM_POINTS - 1);
				dup = 1'b0;
				for (int j = 0; j < k; j++)
					if (pool[j] == p)
						dup = 1'b1;
			end while (dup);
			pool[k] = p;
		end

		settings[0] = REG_W'(2);
		settings[1] = REG_W'($urandom_range(3, 16));
		settings[2] = MAX_ITER;
		settings[3] = {REG_W{1'b1}};
		settings[4] = REG_W'($urandom_range(17, 63));
		settings[5] = REG_W'(1);
		settings[6] = REG_W'($urandom_range(65, 126));
		settings[7] = MAX_ITER;
		settings[8] = '0;
		settings[9] = REG_W'($urandom_range(1, 64));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one iteration compared, extremes of labels and points
		write_reg(REG_W'(1));
		send_item(OP_WRITE, 0, 0, 0, 0);
		send_item(OP_WRITE, 63, 0, 0, 15);
		send_item(OP_WRITE, 63, 63, 63, 15);
		send_item(OP_WRITE, 21, 0, 0, 15);
		send_item(OP_WRITE, 42, 63, 0, 0);
		send_item(OP_QUERY, 0, 63, 0, 0);
		send_item(OP_QUERY, 63, 21, 63, 15);
		send_item(OP_QUERY, 0, 42, 0, 0);
		send_item(OP_QUERY, 63, 63, 0, 0);
		send_item(OP_QUERY, 0, 0, 0, 0);
		send_item(OP_WRITE, 0, 0, 0, 15);
		send_item(OP_QUERY, 0, 63, 0, 0);
		send_item(OP_QUERY, 42, 0, 0, 0);
		settle();
		// zero register reads as one iteration
		write_reg('0);
		send_item(OP_QUERY, 63, 0, 0, 0);
		send_item(OP_QUERY, 21, 42, 0, 0);
		send_item(OP_QUERY, 42, 42, 0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < 4) begin
				send_idle_pct = 12;
				recv_idle_pct = 73;
			end else if (ph < 7) begin
				send_idle_pct = 73;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(settings[ph]);
			repeat (PHASE_ITEMS) random_item();
		end

		// receiver holds off while requests keep coming, so the queue fills
		settle();
		pressure_on <= 1'b1;
		repeat (PRESSURE_ITEMS) random_item();
		settle();

		$display("covered %0d label writes and %0d similarity queries over %0d register settings",
			write_total, query_total, settings_count);
		$display("idling mixes: sender-light, receiver-light, none; one %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/cosq_pkg.sv
rtl/cosq_ram.sv
rtl/cosq_front.sv
rtl/cosq_div.sv
rtl/cosq_back.sv
rtl/coclustering_similarity_query_unit.sv
test/cosq_checker.sv
test/coclustering_similarity_query_unit_tb.sv
